@@ hdl/pwmatch_pkg.sv @@
package pwmatch_pkg;

	// Pattern geometry
	localparam int MaxPattern = 32;
	localparam int PosW       = MaxPattern + 1;
	localparam int LenW       = 6;
	localparam int CharW      = 8;
	localparam int WordW      = 64;
	localparam int NumWords   = (MaxPattern * CharW) / WordW;
	localparam int WordSelW   = $clog2(NumWords);
	localparam int IdxW       = 3;
	localparam int ClsLevels  = $clog2(PosW);

	localparam logic [CharW-1:0] WildcardReset = 8'd42;

	// Configuration register map
	typedef enum logic [IdxW-1:0] {
		REG_WORD0 = 3'd0,
		REG_WORD1 = 3'd1,
		REG_WORD2 = 3'd2,
		REG_WORD3 = 3'd3,
		REG_LEN   = 3'd4,
		REG_WILD  = 3'd5
	} reg_idx_t;

	typedef logic [PosW-1:0] pos_vec_t;

	// Pattern view derived from the registers
	typedef struct packed {
		logic [MaxPattern-1:0][CharW-1:0] pat;
		logic [LenW-1:0]                  used_len;
		logic [MaxPattern-1:0]            in_len;
		logic [MaxPattern-1:0]            star;
	} cfg_t;

	// Hand-off from the step stage to the result stage
	typedef struct packed {
		logic     load;
		pos_vec_t vec;
	} hand_t;

	// Empty-run closure: an active position sitting on a wildcard also
	// activates the next one. Runs of wildcards chain like a carry, so this
	// is a parallel-prefix network of log2 levels.
	function automatic pos_vec_t close_stars(pos_vec_t v, logic [MaxPattern-1:0] star);
		pos_vec_t g;
		pos_vec_t p;
		pos_vec_t g_n;
		pos_vec_t p_n;
		g = v;
		p = {star, 1'b0};
		for (int lvl = 0; lvl < ClsLevels; lvl++) begin
			g_n = g;
			p_n = p;
			for (int j = 0; j < PosW; j++) begin
				if (j >= (1 << lvl)) begin
					g_n[j] = g[j] | (p[j] & g[j - (1 << lvl)]);
					p_n[j] = p[j] & p[j - (1 << lvl)];
				end
			end
			g = g_n;
			p = p_n;
		end
		return g;
	endfunction

endpackage

@@ hdl/pwmatch_cfg.sv @@
module pwmatch_cfg
	import pwmatch_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IdxW-1:0]  cfg_index,
	input  logic [WordW-1:0] cfg_data,
	output cfg_t             cfg
);

	logic [NumWords-1:0][WordW-1:0] word_q;
	logic [LenW-1:0]                len_q;
	logic [CharW-1:0]               wild_q;
	logic [LenW-1:0]                used_len;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			len_q  <= '0;
			wild_q <= WildcardReset;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index)) inside
				REG_WORD0, REG_WORD1, REG_WORD2, REG_WORD3: begin
					word_q[cfg_index[WordSelW-1:0]] <= cfg_data;
				end
				REG_LEN: begin
					len_q <= cfg_data[LenW-1:0];
				end
				REG_WILD: begin
					wild_q <= cfg_data[CharW-1:0];
				end
				default: ;
			endcase
		end
	end

	// Length clip and per-position masks
	assign used_len = (len_q > LenW'(MaxPattern)) ? LenW'(MaxPattern) : len_q;

	always_comb begin
		cfg.pat      = word_q;
		cfg.used_len = used_len;
		for (int i = 0; i < MaxPattern; i++) begin
			cfg.in_len[i] = LenW'(i) < used_len;
			cfg.star[i]   = cfg.in_len[i] && (word_q[i / 8][(i % 8) * CharW +: CharW] == wild_q);
		end
	end

endmodule

@@ hdl/pwmatch_step.sv @@
module pwmatch_step
	import pwmatch_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic [CharW-1:0] path_char,
	input  logic             no_char,
	input  logic             is_last,
	input  cfg_t             cfg,
	input  logic             s2_free,
	output hand_t            hand
);

	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             none_s1;
	logic             last_s1;
	pos_vec_t         active_q;
	pos_vec_t         closed;
	pos_vec_t         adv;
	logic [MaxPattern-1:0] hit;
	logic             s1_go;

	// A non-last beat never waits; a last beat waits for the result stage
	assign s1_go      = valid_s1 && (!last_s1 || s2_free);
	assign item_stall = valid_s1 && !s1_go;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			char_s1 <= path_char;
			none_s1 <= no_char;
			last_s1 <= is_last;
		end
	end

	// Automaton advance: wildcards hold their position, literals step on
	always_comb begin
		closed = close_stars(active_q, cfg.star);
		for (int i = 0; i < MaxPattern; i++) begin
			hit[i] = closed[i] && cfg.in_len[i] && !cfg.star[i] && (cfg.pat[i] == char_s1);
		end
		adv = {hit, 1'b0} | {1'b0, closed[MaxPattern-1:0] & cfg.star};
	end

	// Active position vector; back to position zero after each path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= PosW'(1);
		end else if (s1_go) begin
			if (last_s1) begin
				active_q <= PosW'(1);
			end else if (!none_s1) begin
				active_q <= adv;
			end
		end
	end

	assign hand.load = s1_go && last_s1;
	assign hand.vec  = none_s1 ? active_q : adv;

	// Checks
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> (active_q == PosW'(1)))
		else $error("active vector not restarted after last beat");

	a_stall_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && last_s1 && !s2_free))
		else $error("input stalled without a pending last beat");

	a_hold_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && none_s1 && !last_s1) |=> $stable(active_q))
		else $error("empty beat changed the active vector");

endmodule

@@ hdl/pwmatch_result.sv @@
module pwmatch_result
	import pwmatch_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  hand_t hand,
	output logic  s2_free,
	output logic  result_valid,
	input  logic  result_stall,
	output logic  matched
);

	logic     valid_s2;
	pos_vec_t vec_s2;
	pos_vec_t closed;
	logic     out_free;
	logic     result_valid_q;
	logic     matched_q;

	assign out_free = !result_valid_q || !result_stall;
	assign s2_free  = !valid_s2 || out_free;

	// Final vector of a path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= hand.load;
		end
	end

	always_ff @(posedge clk) begin
		if (hand.load && s2_free) begin
			vec_s2 <= hand.vec;
		end
	end

	// Trailing wildcards may match an empty run; then look at the end position
	assign closed = close_stars(vec_s2, cfg.star);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && out_free) begin
			matched_q <= closed[cfg.used_len];
		end
	end

	assign result_valid = result_valid_q;
	assign matched      = matched_q;

	// Checks
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_free) |=> (valid_s2 && $stable(vec_s2)))
		else $error("pending path vector lost while output blocked");

	a_s2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_free) |=> result_valid_q)
		else $error("path vector dropped on its way to the output");

endmodule

@@ hdl/path_wildcard_matcher_unit.sv @@
// Path wildcard matcher. Path bytes stream in one beat per cycle on the item
// channel (path_char, with is_last on the final beat; no_char marks a beat
// without a byte, as in an empty path). Each path is matched as a whole
// against the configured pattern, where the wildcard byte stands for any run
// of bytes, empty included, and a literal wildcard in the path is matched
// like any other byte. Exactly one result beat (matched) comes out per path,
// via the path-vector and output registers. The block takes one beat every
// cycle: a bit-vector automaton with one bit per pattern position is updated
// in a single registered step, and only a last beat can be held off, when two
// earlier results are still waiting at a stalled output. The user must write
// the configuration registers (pattern words 0 to 3, length, wildcard byte)
// between paths; the block does not enforce it. cfg_ready is always high.
module path_wildcard_matcher_unit
	import pwmatch_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IdxW-1:0]  cfg_index,
	input  logic [WordW-1:0] cfg_data,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic [CharW-1:0] path_char,
	input  logic             no_char,
	input  logic             is_last,
	output logic             result_valid,
	input  logic             result_stall,
	output logic             matched
);

	cfg_t  cfg;
	hand_t hand;
	logic  s2_free;

	pwmatch_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pwmatch_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.path_char  (path_char),
		.no_char    (no_char),
		.is_last    (is_last),
		.cfg        (cfg),
		.s2_free    (s2_free),
		.hand       (hand)
	);

	pwmatch_result u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.hand         (hand),
		.s2_free      (s2_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.matched      (matched)
	);

endmodule

@@ sim/path_wildcard_matcher_unit_tb.sv @@
module path_wildcard_matcher_unit_tb;
	import pwmatch_pkg::*;

	localparam int CycleLimit   = 300000;
	localparam int SettleCycles = 8;
	localparam int RandomItems  = 1400;
	localparam int PhaseItems   = 110;
	localparam int QuietPhase   = 3;
	// Indexes outside the register map: writes there must change nothing
	localparam logic [IdxW-1:0] RegSpare6 = 3'd6;
	localparam logic [IdxW-1:0] RegSpare7 = 3'd7;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             cfg_valid    = 1'b0;
	logic             cfg_ready;
	logic [IdxW-1:0]  cfg_index    = '0;
	logic [WordW-1:0] cfg_data     = '0;
	logic             item_valid   = 1'b0;
	logic             item_stall;
	logic [CharW-1:0] path_char    = '0;
	logic             no_char      = 1'b0;
	logic             is_last      = 1'b0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	logic             matched;

	// Shadow copy of the configuration and of the automaton
	logic [WordW-1:0] pat_words [NumWords] = '{default: '0};
	logic [LenW-1:0]  pat_len   = '0;
	logic [CharW-1:0] wild_byte = WildcardReset;
	pos_vec_t         live_pos  = pos_vec_t'(1);

	logic             match_expect [$];
	logic [CharW-1:0] path_q [$];
	logic [CharW-1:0] alpha [3];

	int idle_pct  = 23;
	int n_fail    = 0;
	int n_items   = 0;
	int cycle_cnt = 0;

	path_wildcard_matcher_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.path_char    (path_char),
		.no_char      (no_char),
		.is_last      (is_last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.matched      (matched)
	);

	always #4 clk = ~clk;

	// Run guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("path_wildcard_matcher_unit_tb failed");
			$finish;
		end
	end

	// Random back-pressure on the result side
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < idle_pct);
	end

	function automatic void note_fail(string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("%s", msg);
	endfunction

	// Compare each result beat with the oldest predicted flag
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (match_expect.size() == 0)
				note_fail($sformatf("unexpected result beat: matched=%b", matched));
			else if (matched !== match_expect[0])
				note_fail($sformatf("matched mismatch: expected %b, got %b",
					match_expect[0], matched));
			if (match_expect.size() != 0)
				void'(match_expect.pop_front());
		end
	end

	// ---- predictor ----

	function automatic int used_len();
		return (int'(pat_len) > MaxPattern) ? MaxPattern : int'(pat_len);
	endfunction

	function automatic logic [CharW-1:0] pat_at(int i);
		return pat_words[i >> 3][(i & 7) * CharW +: CharW];
	endfunction

	// Empty-run closure: a live position on a wildcard also enables the next one
	function automatic pos_vec_t glob_close(pos_vec_t v);
		int n;
		n = used_len();
		for (int i = 0; i < n; i++)
			if (v[i] && pat_at(i) == wild_byte)
				v[i+1] = 1'b1;
		return v;
	endfunction

	function automatic pos_vec_t glob_advance(pos_vec_t v, logic [CharW-1:0] c);
		pos_vec_t nxt;
		int n;
		nxt = '0;
		n = used_len();
		v = glob_close(v);
		for (int i = 0; i < n; i++) begin
			if (v[i]) begin
				if (pat_at(i) == wild_byte)
					nxt[i] = 1'b1;
				else if (pat_at(i) == c)
					nxt[i+1] = 1'b1;
			end
		end
		return nxt;
	endfunction

	function automatic void track_beat(logic [CharW-1:0] c, logic none, logic last);
		pos_vec_t v;
		if (!none)
			live_pos = glob_advance(live_pos, c);
		if (last) begin
			v = glob_close(live_pos);
			match_expect = {match_expect, v[used_len()]};
			live_pos = pos_vec_t'(1);
		end
	endfunction

	// ---- drivers ----

	task automatic send_beat(logic [CharW-1:0] c, logic none, logic last);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		path_char  <= c;
		no_char    <= none;
		is_last    <= last;
		do @(posedge clk); while (item_stall);
		track_beat(c, none, last);
		if (!none || last)
			n_items++;
	endtask

	// Send path_q as one path; optionally close it with a byte-less last beat
	task automatic send_path(bit tail_empty, bit noise);
		int n;
		n = path_q.size();
		if (n == 0)
			tail_empty = 1'b1;
		for (int k = 0; k < n; k++) begin
			if (noise && $urandom_range(19) == 0)
				send_beat(8'($urandom_range(255)), 1'b1, 1'b0);
			send_beat(path_q[k], 1'b0, !tail_empty && k == n - 1);
		end
		if (tail_empty)
			send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
	endtask

	// Wait for every pending result, then let the pipeline empty
	task automatic settle();
		item_valid <= 1'b0;
		while (match_expect.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [IdxW-1:0] idx, logic [WordW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WORD0, REG_WORD1, REG_WORD2, REG_WORD3: pat_words[idx[1:0]] = data;
			REG_LEN:  pat_len   = data[LenW-1:0];
			REG_WILD: wild_byte = data[CharW-1:0];
			default: ;
		endcase
	endtask

	task automatic program_all(logic [WordW-1:0] w0, logic [WordW-1:0] w1,
			logic [WordW-1:0] w2, logic [WordW-1:0] w3,
			logic [WordW-1:0] len_data, logic [WordW-1:0] wild_data);
		settle();
		write_reg(REG_WORD0, w0);
		write_reg(REG_WORD1, w1);
		write_reg(REG_WORD2, w2);
		write_reg(REG_WORD3, w3);
		write_reg(REG_LEN, len_data);
		write_reg(REG_WILD, wild_data);
		cfg_valid <= 1'b0;
	endtask

	task automatic put(logic [CharW-1:0] c);
		path_q = {path_q, c};
	endtask

	// ---- tests ----

	// Reset values: empty pattern, default wildcard
	task automatic test_after_reset();
		path_q.delete();
		send_path(1'b1, 1'b0);
		path_q.delete(); put("a");
		send_path(1'b0, 1'b0);
		settle();
		write_reg(REG_WORD0, 64'h2A);
		write_reg(REG_LEN, 64'd1);
		cfg_valid <= 1'b0;
		path_q.delete(); put("z"); put("z");
		send_path(1'b0, 1'b0);
	endtask

	// "a*b": literal wildcard in the path, ignored beats, byte-less last beat
	task automatic test_wildcard_paths();
		program_all({40'd0, "b", 8'h2A, "a"}, '0, '0, '0, 64'd3, 64'd42);
		path_q.delete(); put("a"); put("b");
		send_path(1'b0, 1'b0);
		path_q.delete(); put("a"); put(8'h2A); put("b");
		send_path(1'b0, 1'b0);
		send_beat("a", 1'b0, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat("b", 1'b0, 1'b1);
		path_q.delete(); put("a"); put("b");
		send_path(1'b1, 1'b0);
		path_q.delete(); put("b"); put("a");
		send_path(1'b0, 1'b0);
	endtask

	// Length above the maximum, full-width pattern, wildcard chains
	task automatic test_length_limits();
		program_all('1, '1, '1, '1, 64'd63, 64'hFF);
		path_q.delete();
		send_path(1'b1, 1'b0);
		path_q.delete(); put(8'h00);
		send_path(1'b0, 1'b0);
		program_all('1, '1, '1, 64'h00FF_FFFF_FFFF_FFFF, 64'd32, 64'hFF);
		path_q.delete(); put(8'h00);
		send_path(1'b0, 1'b0);
		path_q.delete(); put(8'hFF);
		send_path(1'b0, 1'b0);
	endtask

	// Writes to unmapped indexes leave the setting alone
	task automatic test_spare_index();
		settle();
		write_reg(RegSpare6, '0);
		write_reg(RegSpare7, '0);
		cfg_valid <= 1'b0;
		path_q.delete(); put(8'h00);
		send_path(1'b0, 1'b0);
	endtask

	function automatic logic [CharW-1:0] rand_byte();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 8'($urandom_range(255));
		if (r < 25)
			return wild_byte;
		return alpha[$urandom_range(2)];
	endfunction

	task automatic random_setting();
		logic [CharW-1:0] pb [MaxPattern];
		logic [WordW-1:0] w [NumWords];
		logic [WordW-1:0] len_data;
		logic [WordW-1:0] wild_data;
		logic [CharW-1:0] wc;
		logic [LenW-1:0]  ln;
		int r;
		wc = $urandom_range(1) ? WildcardReset : 8'($urandom_range(255));
		for (int a = 0; a < 3; a++)
			alpha[a] = 8'($urandom_range(255));
		r = $urandom_range(99);
		if (r < 5)
			ln = '0;
		else if (r < 12)
			ln = LenW'(MaxPattern);
		else if (r < 17)
			ln = LenW'($urandom_range(63, MaxPattern + 1));
		else
			ln = LenW'($urandom_range(10, 1));
		for (int i = 0; i < MaxPattern; i++) begin
			if (i >= int'(ln))
				pb[i] = 8'($urandom_range(255));
			else if ($urandom_range(99) < 30)
				pb[i] = wc;
			else
				pb[i] = alpha[$urandom_range(2)];
		end
		for (int k = 0; k < NumWords; k++)
			for (int j = 0; j < WordW / CharW; j++)
				w[k][j*CharW +: CharW] = pb[k * (WordW / CharW) + j];
		// upper data bits are don't-care for the narrow registers
		len_data = {$urandom, $urandom};
		len_data[LenW-1:0] = ln;
		wild_data = {$urandom, $urandom};
		wild_data[CharW-1:0] = wc;
		program_all(w[0], w[1], w[2], w[3], len_data, wild_data);
	endtask

	// Mostly paths built from the pattern, some with one edit, some noise
	task automatic build_path();
		int r;
		int n;
		int pos;
		path_q.delete();
		r = $urandom_range(99);
		n = used_len();
		if (r < 85) begin
			for (int i = 0; i < n; i++) begin
				if (pat_at(i) == wild_byte)
					repeat ($urandom_range(3)) put(rand_byte());
				else
					put(pat_at(i));
			end
			if (r >= 65) begin
				if (path_q.size() == 0) begin
					put(rand_byte());
				end else begin
					pos = $urandom_range(path_q.size() - 1);
					case ($urandom_range(2))
						0: path_q[pos] = rand_byte();
						1: path_q.delete(pos);
						default: path_q.insert(pos, rand_byte());
					endcase
				end
			end
		end else begin
			repeat ($urandom_range(8)) put(rand_byte());
		end
	endtask

	task automatic test_random_traffic();
		int phase;
		int start;
		phase = 0;
		start = n_items;
		while (n_items - start < RandomItems) begin
			random_setting();
			idle_pct = (phase == QuietPhase) ? 0 : 23;
			begin
				int p0;
				p0 = n_items;
				while (n_items - p0 < PhaseItems) begin
					build_path();
					send_path($urandom_range(9) == 0, 1'b1);
				end
			end
			phase++;
		end
		idle_pct = 23;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		settle();
		test_after_reset();
		test_wildcard_paths();
		test_length_limits();
		test_spare_index();
		test_random_traffic();
		settle();
		if (n_fail == 0 && match_expect.size() == 0)
			$display("path_wildcard_matcher_unit_tb passed");
		else
			$display("path_wildcard_matcher_unit_tb failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/pwmatch_pkg.sv
hdl/pwmatch_cfg.sv
hdl/pwmatch_step.sv
hdl/pwmatch_result.sv
hdl/path_wildcard_matcher_unit.sv
sim/path_wildcard_matcher_unit_tb.sv
